// File: sv/glyph_cell_bitplane_writer_unit_assert.svh
// assertion macros for the glyph cell bitplane writer checker
`ifndef GLYPH_CELL_BITPLANE_WRITER_UNIT_ASSERT_SVH
`define GLYPH_CELL_BITPLANE_WRITER_UNIT_ASSERT_SVH

// overlapping implication, off while reset is held
`define GCBW_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define GCBW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also checks across reset
`define GCBW_ASSERT_RAW_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/gcbw_pkg.sv
// types, constants and helper functions of the glyph cell bitplane writer
package gcbw_pkg;

    localparam int GLYPH_COUNT_DEF = 96;
    localparam int GLYPH_ROWS      = 8;

    localparam logic [7:0] CHAR_FIRST  = 8'd32;
    localparam logic [7:0] CHAR_LAST   = 8'd127;
    localparam logic [7:0] HL_EVEN     = 8'hAA;
    localparam logic [7:0] HL_ODD      = 8'h55;
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    localparam logic KIND_DRAW = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    localparam logic [1:0] RST_WIDE_MODE   = 2'd0;
    localparam logic [1:0] RST_PLANE_COUNT = 2'd3;
    localparam logic [7:0] RST_BPL         = 8'd80;
    localparam logic [7:0] RST_COL_LIMIT   = 8'd80;
    localparam logic [7:0] RST_ROW_LIMIT   = 8'd60;

    typedef enum logic [2:0] {
        CFG_WIDE_MODE      = 3'd0,
        CFG_PLANE_COUNT    = 3'd1,
        CFG_BYTES_PER_LINE = 3'd2,
        CFG_COL_LIMIT      = 3'd3,
        CFG_ROW_LIMIT      = 3'd4,
        CFG_ORIGIN_COL     = 3'd5,
        CFG_ORIGIN_ROW     = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    function automatic logic [7:0] double_nibble(input logic [3:0] n);
        logic [7:0] r;
        r = '0;
        for (int b = 0; b < 4; b++) begin
            r[2*b]   = n[b];
            r[2*b+1] = n[b];
        end
        return r;
    endfunction

    function automatic logic [7:0] level_mask(input logic [1:0] lvl);
        logic [7:0] m;
        unique case (lvl)
            2'd0:    m = 8'h00;
            2'd1:    m = HL_ODD;
            2'd2:    m = HL_EVEN;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

// File: sv/glyph_cell_bitplane_writer_unit.sv
// glyph cell bitplane writer: font store, glyph fetch and plane write sequencer
// load item: written to the font store when its index is in range, no result
// draw item outside the limits or with no planes: dropped, no result
// draw item: glyph fetch from the font memory read port (or the highlight pattern), then one
// write per cycle while the receiver is ready, 8 x planes (narrow) or 16 x planes (wide)
// reset clears the sequencer and sets the registers to their defaults; font store not cleared
module glyph_cell_bitplane_writer_unit
    import gcbw_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // col, row, colour, char_code, highlight, font_index, font_byte, pad
    input  logic [47:0] s_tdata,
    // kind
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // plane, byte_offset, pixel_byte, pad
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_data
);

    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW          = $clog2(STORE_DEPTH);

    logic [6:0] in_col, in_row;
    logic [5:0] in_colour;
    logic [7:0] in_char;
    logic       in_hl;
    logic [9:0] in_findex;
    logic [7:0] in_fbyte;

    assign in_col    = s_tdata[6:0];
    assign in_row    = s_tdata[13:7];
    assign in_colour = s_tdata[19:14];
    assign in_char   = s_tdata[27:20];
    assign in_hl     = s_tdata[28];
    assign in_findex = s_tdata[38:29];
    assign in_fbyte  = s_tdata[46:39];

    logic       wide_mode_reg;
    logic [1:0] plane_count_reg;
    logic [7:0] bpl_reg, col_limit_reg, row_limit_reg;
    logic [6:0] origin_col_reg, origin_row_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_mode_reg   <= RST_WIDE_MODE[0];
            plane_count_reg <= RST_PLANE_COUNT;
            bpl_reg         <= RST_BPL;
            col_limit_reg   <= RST_COL_LIMIT;
            row_limit_reg   <= RST_ROW_LIMIT;
            origin_col_reg  <= '0;
            origin_row_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_WIDE_MODE:      wide_mode_reg   <= cfg_data[0];
                CFG_PLANE_COUNT:    plane_count_reg <= cfg_data[1:0];
                CFG_BYTES_PER_LINE: bpl_reg         <= cfg_data;
                CFG_COL_LIMIT:      col_limit_reg   <= cfg_data;
                CFG_ROW_LIMIT:      row_limit_reg   <= cfg_data;
                CFG_ORIGIN_COL:     origin_col_reg  <= cfg_data[6:0];
                CFG_ORIGIN_ROW:     origin_row_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    state_t      state_reg, state_next;
    logic [3:0]  fetch_reg, fetch_next;
    logic [6:0]  glyph_reg, glyph_next;
    logic        hl_reg, hl_next;
    logic [5:0]  colour_reg, colour_next;
    logic [7:0]  col_sum_reg, col_sum_next;
    logic [7:0]  row_sum_reg, row_sum_next;
    logic [18:0] line0_reg, line0_next;
    logic [18:0] line_reg, line_next;
    logic [2:0]  grow_reg, grow_next;
    logic [1:0]  plane_reg, plane_next;
    logic        half_reg, half_next;
    logic [7:0]  gbuf_reg [GLYPH_ROWS];
    logic [7:0]  gbuf_next [GLYPH_ROWS];
    logic        m_tvalid_reg, m_tvalid_next;
    logic        m_tlast_reg, m_tlast_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    // font store
    logic [7:0]    font_mem [STORE_DEPTH];
    logic [7:0]    rd_reg;
    logic [AW-1:0] rd_addr;
    logic          load_wr;

    assign load_wr = (state_reg == ST_IDLE) && s_tvalid && (s_tuser == KIND_LOAD)
                     && ({1'b0, AW'(in_findex)} < (AW+1)'(STORE_DEPTH));
    assign rd_addr = AW'({glyph_reg, fetch_reg[2:0]});

    always_ff @(posedge aclk) begin
        if (load_wr) begin
            font_mem[AW'(in_findex)] <= in_fbyte;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= font_mem[rd_addr];
    end

    logic [7:0]  char_c, char_off;
    logic        in_range;
    logic [18:0] line_prod;
    logic [7:0]  g_row, nib_x2, pix;
    logic        cbit;
    logic [1:0]  lvl;
    logic [8:0]  col_term;
    logic [18:0] off;
    logic        is_last, out_free;
    logic [2:0]  fidx;

    always_comb begin
        char_c    = (in_char < CHAR_FIRST || in_char > CHAR_LAST) ? CHAR_FIRST : in_char;
        char_off  = char_c - CHAR_FIRST;
        in_range  = ({1'b0, in_col} < col_limit_reg) && ({1'b0, in_row} < row_limit_reg)
                    && (plane_count_reg != 2'd0);
        line_prod = {8'd0, row_sum_reg, 3'b000} * {11'd0, bpl_reg};
        fidx      = 3'(fetch_reg - 4'd1);

        g_row = gbuf_reg[grow_reg];
        unique case (plane_reg)
            2'd0: begin
                cbit = colour_reg[0];
                lvl  = colour_reg[1:0];
            end
            2'd1: begin
                cbit = colour_reg[1];
                lvl  = colour_reg[3:2];
            end
            default: begin
                cbit = colour_reg[2];
                lvl  = colour_reg[5:4];
            end
        endcase
        nib_x2   = half_reg ? double_nibble(4'(g_row & NIBBLE_MASK))
                            : double_nibble(g_row[7:4]);
        pix      = wide_mode_reg ? (nib_x2 & level_mask(lvl)) : (cbit ? g_row : 8'd0);
        col_term = wide_mode_reg ? ({col_sum_reg, 1'b0} + {8'd0, half_reg})
                                 : {1'b0, col_sum_reg};
        off      = line_reg + 19'(col_term);
        is_last  = (plane_reg == 2'(plane_count_reg - 2'd1)) && (grow_reg == 3'd7)
                   && (half_reg || !wide_mode_reg);
        out_free = !m_tvalid_reg || m_tready;

        state_next    = state_reg;
        fetch_next    = fetch_reg;
        glyph_next    = glyph_reg;
        hl_next       = hl_reg;
        colour_next   = colour_reg;
        col_sum_next  = col_sum_reg;
        row_sum_next  = row_sum_reg;
        line0_next    = line0_reg;
        line_next     = line_reg;
        grow_next     = grow_reg;
        plane_next    = plane_reg;
        half_next     = half_reg;
        gbuf_next     = gbuf_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tlast_next  = m_tlast_reg;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && (s_tuser == KIND_DRAW) && in_range) begin
                    state_next   = ST_FETCH;
                    fetch_next   = '0;
                    glyph_next   = char_off[6:0];
                    hl_next      = in_hl;
                    colour_next  = in_colour;
                    col_sum_next = {1'b0, in_col} + {1'b0, origin_col_reg};
                    row_sum_next = {1'b0, in_row} + {1'b0, origin_row_reg};
                end
            end
            ST_FETCH: begin
                if (fetch_reg == 4'd0) begin
                    line0_next = line_prod;
                end else begin
                    gbuf_next[fidx] = hl_reg ? (fidx[0] ? HL_ODD : HL_EVEN) : rd_reg;
                end
                if (fetch_reg == 4'd8) begin
                    state_next = ST_EMIT;
                    line_next  = line0_reg;
                    grow_next  = '0;
                    plane_next = '0;
                    half_next  = 1'b0;
                end else begin
                    fetch_next = fetch_reg + 4'd1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = is_last;
                    m_tdata_next  = {3'b000, pix, off, plane_reg};
                    if (wide_mode_reg && !half_reg) begin
                        half_next = 1'b1;
                    end else begin
                        half_next = 1'b0;
                        if (grow_reg == 3'd7) begin
                            grow_next  = '0;
                            plane_next = plane_reg + 2'd1;
                            line_next  = line0_reg;
                        end else begin
                            grow_next = grow_reg + 3'd1;
                            line_next = line_reg + {11'd0, bpl_reg};
                        end
                    end
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fetch_reg   <= fetch_next;
        glyph_reg   <= glyph_next;
        hl_reg      <= hl_next;
        colour_reg  <= colour_next;
        col_sum_reg <= col_sum_next;
        row_sum_reg <= row_sum_next;
        line0_reg   <= line0_next;
        line_reg    <= line_next;
        grow_reg    <= grow_next;
        plane_reg   <= plane_next;
        half_reg    <= half_next;
        gbuf_reg    <= gbuf_next;
        m_tlast_reg <= m_tlast_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: sv/gcbw_checker.sv
// port-level checker for the glyph cell bitplane writer, bound to the top level
`include "glyph_cell_bitplane_writer_unit_assert.svh"

module gcbw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tvalid,
    input logic        m_tready
);

    // no result survives reset
    `GCBW_ASSERT_RAW_NEXT(a_reset_clears_out, aclk, !aresetn, !m_tvalid, "result after reset")

    // the block only goes busy on an input transfer
    `GCBW_ASSERT_IMP(a_busy_after_transfer, aclk, aresetn, $fell(s_tready),
                     $past(s_tvalid), "busy without input transfer")

    // a new result is only produced while an item is in progress
    `GCBW_ASSERT_IMP(a_result_while_busy, aclk, aresetn, $rose(m_tvalid),
                     $past(!s_tready), "result appeared while idle")

    // a stalled result holds
    `GCBW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind glyph_cell_bitplane_writer_unit gcbw_checker u_gcbw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// File: verif/glyph_cell_bitplane_writer_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the glyph cell bitplane writer: directed and random font loads and cell draws

module glyph_cell_bitplane_writer_unit_tb
    import gcbw_pkg::*;
;

    localparam int STORE_DEPTH = GLYPH_COUNT_DEF * GLYPH_ROWS;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 500;

    typedef struct packed {
        logic       kind;
        logic [6:0] col;
        logic [6:0] row;
        logic [5:0] colour;
        logic [7:0] code;
        logic       hl;
        logic [9:0] fidx;
        logic [7:0] fbyte;
    } cell_item_t;

    typedef struct {
        logic [1:0]  plane;
        logic [18:0] offset;
        logic [7:0]  pixel;
        logic        last;
    } plane_write_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [47:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tvalid  = 1'b0;
    wire         s_tready;
    wire  [31:0] m_tdata;
    wire         m_tlast;
    wire         m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [2:0]  cfg_addr  = '0;
    logic [7:0]  cfg_data  = '0;

    // copy of the register file as the block should hold it
    logic        mode_wide   = RST_WIDE_MODE[0];
    logic [1:0]  plane_total = RST_PLANE_COUNT;
    logic [7:0]  line_bytes  = RST_BPL;
    logic [7:0]  cols_max    = RST_COL_LIMIT;
    logic [7:0]  rows_max    = RST_ROW_LIMIT;
    logic [6:0]  win_col     = '0;
    logic [6:0]  win_row     = '0;

    logic [7:0]  glyph_rom [STORE_DEPTH];
    bit          glyph_row_known [STORE_DEPTH];

    cell_item_t   cells_pending [$];
    plane_write_t writes_due [$];
    cell_item_t   offered;
    plane_write_t got_write;
    plane_write_t due_write;

    int          idle_pct     = 30;
    int          send_gap     = 0;
    int          sink_wait    = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    int unsigned results_seen = 0;
    int          quiet_cycles = 0;
    int          fault_count  = 0;

    glyph_cell_bitplane_writer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [7:0] spread_nibble(logic [3:0] n);
        logic [7:0] v;
        v = '0;
        for (int b = 0; b < 4; b++) begin
            if (n[b]) begin
                v[2*b +: 2] = 2'b11;
            end
        end
        return v;
    endfunction

    // expected writes for one accepted item, appended to writes_due; a load item updates glyph_rom
    function automatic void render_cell(cell_item_t it);
        logic [7:0]   code;
        logic [7:0]   rows [GLYPH_ROWS];
        logic [7:0]   mask;
        int unsigned  line;
        int unsigned  base;
        plane_write_t w;
        int           n;
        n = 0;
        if (it.kind == KIND_LOAD) begin
            if (it.fidx < STORE_DEPTH) begin
                glyph_rom[it.fidx] = it.fbyte;
            end
            return;
        end
        code = it.code;
        if (code < CHAR_FIRST || code > CHAR_LAST) begin
            code = CHAR_FIRST;
        end
        if (it.col >= cols_max || it.row >= rows_max) begin
            return;
        end
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            if (it.hl) begin
                rows[r] = (r % 2) ? HL_ODD : HL_EVEN;
            end else begin
                rows[r] = glyph_rom[(int'(code) - int'(CHAR_FIRST)) * GLYPH_ROWS + r];
            end
        end
        for (int p = 0; p < int'(plane_total); p++) begin
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                line = ((int'(it.row) + int'(win_row)) * 8 + r) * int'(line_bytes);
                w.plane = 2'(p);
                w.last  = 1'b0;
                if (!mode_wide) begin
                    base     = int'(it.col) + int'(win_col) + line;
                    w.offset = base[18:0];
                    w.pixel  = it.colour[p] ? rows[r] : 8'h00;
                    writes_due.push_back(w);
                    n++;
                end else begin
                    mask     = {4{it.colour[2*p +: 2]}};
                    base     = (int'(it.col) + int'(win_col)) * 2 + line;
                    w.offset = base[18:0];
                    w.pixel  = spread_nibble(rows[r][7:4]) & mask;
                    writes_due.push_back(w);
                    base     = base + 1;
                    w.offset = base[18:0];
                    w.pixel  = spread_nibble(rows[r][3:0]) & mask;
                    writes_due.push_back(w);
                    n += 2;
                end
            end
        end
        if (n > 0) begin
            writes_due[writes_due.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 60);
    endfunction

    function automatic cell_item_t noise_item();
        logic [63:0] raw;
        cell_item_t  it;
        raw = {$urandom, $urandom};
        it  = raw[47:0];
        return it;
    endfunction

    function automatic void queue_load(int idx, logic [7:0] val);
        cell_item_t it;
        it       = noise_item();
        it.kind  = KIND_LOAD;
        it.fidx  = 10'(idx);
        it.fbyte = val;
        if (idx < STORE_DEPTH) begin
            glyph_row_known[idx] = 1'b1;
        end
        cells_pending.push_back(it);
    endfunction

    function automatic void queue_draw(logic [6:0] col, logic [6:0] row, logic [5:0] colour,
                                       logic [7:0] code, logic hl);
        cell_item_t it;
        it        = noise_item();
        it.kind   = KIND_DRAW;
        it.col    = col;
        it.row    = row;
        it.colour = colour;
        it.code   = code;
        it.hl     = hl;
        cells_pending.push_back(it);
    endfunction

    function automatic bit glyph_ready(logic [7:0] code);
        int first;
        if (code < CHAR_FIRST || code > CHAR_LAST) begin
            code = CHAR_FIRST;
        end
        first = (int'(code) - int'(CHAR_FIRST)) * GLYPH_ROWS;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            if (!glyph_row_known[first + r]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [6:0] pick_cell(logic [7:0] lim);
        int top;
        if (lim == 0 || $urandom_range(0, 4) == 0) begin
            return 7'($urandom_range(0, 127));
        end
        top = (lim > 128) ? 128 : int'(lim);
        return 7'($urandom_range(0, top - 1));
    endfunction

    // never lets a draw read a font row that was not loaded
    function automatic void queue_random_draw();
        logic [7:0] code;
        logic       hl;
        code = 8'($urandom_range(0, 255));
        hl   = ($urandom_range(0, 99) < 15);
        if (!hl && !glyph_ready(code)) begin
            if ($urandom_range(0, 1)) begin
                hl = 1'b1;
            end else begin
                code = 8'($urandom_range(128, 255));
            end
        end
        queue_draw(pick_cell(cols_max), pick_cell(rows_max), 6'($urandom_range(0, 63)),
                   code, hl);
    endfunction

    function automatic void queue_random_phase(int count);
        int n;
        int pick;
        int g;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                g = $urandom_range(0, GLYPH_COUNT_DEF - 1);
                for (int r = 0; r < GLYPH_ROWS; r++) begin
                    queue_load(g * GLYPH_ROWS + r, 8'($urandom_range(0, 255)));
                end
                n += GLYPH_ROWS;
            end else if (pick == 2) begin
                queue_load($urandom_range(0, 1023), 8'($urandom_range(0, 255)));
                n++;
            end else begin
                queue_random_draw();
                n++;
            end
        end
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDE_MODE:      mode_wide   = val[0];
            CFG_PLANE_COUNT:    plane_total = val[1:0];
            CFG_BYTES_PER_LINE: line_bytes  = val;
            CFG_COL_LIMIT:      cols_max    = val;
            CFG_ROW_LIMIT:      rows_max    = val;
            CFG_ORIGIN_COL:     win_col     = val[6:0];
            CFG_ORIGIN_ROW:     win_row     = val[6:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic wide, logic [1:0] planes, logic [7:0] bpl,
                                 logic [7:0] col_lim, logic [7:0] row_lim,
                                 logic [6:0] org_col, logic [6:0] org_row);
        write_reg(CFG_WIDE_MODE, {7'b0, wide});
        write_reg(CFG_PLANE_COUNT, {6'b0, planes});
        write_reg(CFG_BYTES_PER_LINE, bpl);
        write_reg(CFG_COL_LIMIT, col_lim);
        write_reg(CFG_ROW_LIMIT, row_lim);
        write_reg(CFG_ORIGIN_COL, {1'b0, org_col});
        write_reg(CFG_ORIGIN_ROW, {1'b0, org_row});
    endtask

    // loads leave no trace, so wait on past the last expected write
    task automatic settle();
        @(negedge aclk);
        while (cells_pending.size() != 0 || s_tvalid || writes_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (20) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                render_cell(offered);
                if (hold_left == 0 && $urandom_range(0, 99) < idle_pct) begin
                    send_gap = pick_gap();
                end
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0 && hold_left == 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (cells_pending.size() != 0) begin
                    offered = cells_pending.pop_front();
                    s_tdata  <= {1'b0, offered.fbyte, offered.fidx, offered.hl, offered.code,
                                 offered.colour, offered.row, offered.col};
                    s_tuser  <= offered.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got_write.plane  = m_tdata[1:0];
                got_write.offset = m_tdata[20:2];
                got_write.pixel  = m_tdata[28:21];
                got_write.last   = m_tlast;
                if (writes_due.size() == 0) begin
                    $display("%0t unexpected write: plane %0d offset %0d byte %02h last %0b",
                             $time, got_write.plane, got_write.offset, got_write.pixel,
                             got_write.last);
                    fault_count++;
                end else begin
                    due_write = writes_due.pop_front();
                    if (got_write.plane !== due_write.plane) begin
                        $display("%0t plane: expected %0d, got %0d", $time,
                                 due_write.plane, got_write.plane);
                        fault_count++;
                    end
                    if (got_write.offset !== due_write.offset) begin
                        $display("%0t byte_offset: expected %0d, got %0d", $time,
                                 due_write.offset, got_write.offset);
                        fault_count++;
                    end
                    if (got_write.pixel !== due_write.pixel) begin
                        $display("%0t pixel_byte: expected %02h, got %02h", $time,
                                 due_write.pixel, got_write.pixel);
                        fault_count++;
                    end
                    if (got_write.last !== due_write.last) begin
                        $display("%0t last: expected %0b, got %0b", $time,
                                 due_write.last, got_write.last);
                        fault_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                sink_wait = pick_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one long receiver hold-off to back the block up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // space glyph first: every clamped code falls back on it
        queue_load(0, 8'h00);
        queue_load(1, 8'hFF);
        queue_load(2, 8'h81);
        queue_load(3, 8'h42);
        queue_load(4, 8'h24);
        queue_load(5, 8'h18);
        queue_load(6, 8'hA5);
        queue_load(7, 8'h5A);
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            queue_load(STORE_DEPTH - GLYPH_ROWS + r, 8'($urandom_range(0, 255)));
        end
        queue_load(STORE_DEPTH, 8'hFF);
        queue_load(1023, 8'h7E);
        queue_draw(7'd0, 7'd0, 6'd63, 8'd32, 1'b0);
        queue_draw(7'd79, 7'd59, 6'h15, 8'd127, 1'b0);
        queue_draw(7'd3, 7'd4, 6'd63, 8'd0, 1'b0);
        queue_draw(7'd5, 7'd5, 6'h2A, 8'd255, 1'b0);
        queue_draw(7'd6, 7'd6, 6'd63, 8'd31, 1'b0);
        queue_draw(7'd7, 7'd7, 6'd63, 8'd128, 1'b0);
        queue_draw(7'd10, 7'd10, 6'h07, 8'd100, 1'b1);
        queue_draw(7'd80, 7'd0, 6'd63, 8'd32, 1'b0);
        queue_draw(7'd0, 7'd60, 6'd63, 8'd32, 1'b0);
        queue_draw(7'd127, 7'd127, 6'd0, 8'd32, 1'b0);
        queue_draw(7'd1, 7'd2, 6'd0, 8'd127, 1'b0);
        settle();

        apply_setting(1'b1, 2'd3, 8'd255, 8'd255, 8'd255, 7'd127, 7'd127);
        idle_pct = 30;
        queue_random_phase(45);
        settle();

        // no row fits, so nothing may come out
        apply_setting(1'b0, 2'd1, 8'd1, 8'd1, 8'd0, 7'd0, 7'd0);
        queue_random_phase(12);
        settle();

        apply_setting(1'b0, 2'd2, 8'd80, 8'd128, 8'd128, 7'd0, 7'd0);
        idle_pct = 0;
        queue_random_phase(45);
        settle();

        apply_setting(1'b1, 2'd1, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 128)),
                      8'($urandom_range(1, 128)), 7'($urandom_range(0, 127)),
                      7'($urandom_range(0, 127)));
        idle_pct = 50;
        queue_random_phase(40);
        settle();

        // zero planes: cells in range still give nothing
        apply_setting(1'b0, 2'd0, 8'd100, 8'd128, 8'd128, 7'd5, 7'd5);
        idle_pct = 20;
        queue_random_phase(10);
        settle();

        apply_setting(1'b1, 2'd2, 8'd40, 8'd40, 8'd30, 7'd3, 7'd2);
        idle_pct = 30;
        queue_random_phase(40);
        settle();

        apply_setting(1'b0, 2'd3, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 128)),
                      8'($urandom_range(1, 128)), 7'($urandom_range(0, 127)),
                      7'($urandom_range(0, 127)));
        idle_pct = 60;
        queue_random_phase(40);
        settle();

        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/gcbw_pkg.sv
sv/glyph_cell_bitplane_writer_unit.sv
sv/gcbw_checker.sv
verif/glyph_cell_bitplane_writer_unit_tb.sv
